// ----- rtl/core/ptt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the periodic task timer bank.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int MAX_TASKS = 16;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;
    localparam logic [1:0] KIND_IDLE   = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [15:0] task_id;
        logic [31:0] interval_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        ok;
        logic [15:0] fired_id;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] task_id;
        logic [31:0] interval_ms;
        logic [31:0] last_ms;
    } t_entry;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic rd_next;
        logic wr_tick;
        logic wr_add;
        logic wr_shift;
        logic idx_inc;
        logic cnt_inc;
        logic cnt_dec;
        logic set_ok;
        logic take_pend;
        logic emit_pend;
        logic emit_final;
    } t_ctl_cmd;

    typedef struct packed {
        logic [1:0] new_req;
        logic [1:0] req;
        logic       cnt_zero;
        logic       full;
        logic       idx_end;
        logic       idx_end2;
        logic       due;
        logic       match;
        logic       pend_valid;
        logic       out_free;
    } t_ctl_sts;

endpackage
`default_nettype wire

// ----- rtl/core/ptt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/ptt_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_datapath
// Request registers, task list RAM, walk index, pending fire and output
// register.
// ----------------------------------------------------------------------------
module ptt_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ptt_pkg::t_in_item i_in_item,
    input  wire ptt_pkg::t_ctl_cmd i_cmd,
    output ptt_pkg::t_ctl_sts      o_sts,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output ptt_pkg::t_out_item     o_out_item
);

    import ptt_pkg::*;

    logic [1:0]       r_req;
    logic [31:0]      r_now;
    logic [15:0]      r_id;
    logic [31:0]      r_interval;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_ok;
    logic             r_pend_valid;
    logic [15:0]      r_pend_id;
    logic             r_out_valid;
    t_out_item        r_out_item;

    t_entry           rd_entry;
    t_entry           wr_entry;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    logic [IDX_W-1:0] idx_addr;
    logic [CNT_W:0]   idx_p1;
    logic [CNT_W:0]   idx_p2;
    logic [31:0]      elapsed;
    logic             out_free;
    t_out_item        final_item;

    assign idx_addr = r_idx[IDX_W-1:0];
    assign idx_p1   = {1'b0, r_idx} + {{CNT_W{1'b0}}, 1'b1};
    assign idx_p2   = {1'b0, r_idx} + (CNT_W + 1)'(2);
    assign elapsed  = r_now - rd_entry.last_ms;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        ram_we    = i_cmd.wr_tick || i_cmd.wr_add || i_cmd.wr_shift;
        ram_waddr = idx_addr;
        wr_entry  = rd_entry;
        ram_raddr = i_cmd.rd_next ? idx_p1[IDX_W-1:0] : idx_addr;
        if (i_cmd.wr_add) begin
            ram_waddr            = r_count[IDX_W-1:0];
            wr_entry.task_id     = r_id;
            wr_entry.interval_ms = r_interval;
            wr_entry.last_ms     = r_now;
        end else if (i_cmd.wr_tick) begin
            wr_entry.last_ms = r_now;
        end
    end

    ptt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    always_comb begin
        final_item      = '0;
        final_item.last = 1'b1;
        unique case (r_req)
            REQ_TICK: begin
                if (r_pend_valid) begin
                    final_item.result_kind = KIND_FIRED;
                    final_item.ok          = 1'b1;
                    final_item.fired_id    = r_pend_id;
                end else begin
                    final_item.result_kind = KIND_IDLE;
                end
            end
            REQ_ADD: begin
                final_item.result_kind = KIND_ADD;
                final_item.ok          = r_ok;
                final_item.fired_id    = r_id;
            end
            default: begin
                final_item.result_kind = KIND_REMOVE;
                final_item.ok          = r_ok;
                final_item.fired_id    = r_id;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= i_in_item.req_type;
            r_now      <= i_in_item.now_ms;
            r_id       <= i_in_item.task_id;
            r_interval <= i_in_item.interval_ms;
        end
        if (i_cmd.take_pend) begin
            r_pend_id <= rd_entry.task_id;
        end
        if (i_cmd.emit_final) begin
            r_out_item <= final_item;
        end else if (i_cmd.emit_pend) begin
            r_out_item.result_kind <= KIND_FIRED;
            r_out_item.ok          <= 1'b1;
            r_out_item.fired_id    <= r_pend_id;
            r_out_item.last        <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idx        <= '0;
            r_ok         <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.load) begin
                r_idx        <= '0;
                r_ok         <= 1'b0;
                r_pend_valid <= 1'b0;
            end else begin
                if (i_cmd.idx_inc) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (i_cmd.set_ok) begin
                    r_ok <= 1'b1;
                end
                if (i_cmd.take_pend) begin
                    r_pend_valid <= 1'b1;
                end
            end
            if (i_cmd.emit_final || i_cmd.emit_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.new_req    = i_in_item.req_type;
        o_sts.req        = r_req;
        o_sts.cnt_zero   = (r_count == '0);
        o_sts.full       = (r_count == CNT_W'(MAX_TASKS));
        o_sts.idx_end    = (idx_p1 >= {1'b0, r_count});
        o_sts.idx_end2   = (idx_p2 >= {1'b0, r_count});
        o_sts.due        = (elapsed >= rd_entry.interval_ms);
        o_sts.match      = (rd_entry.task_id == r_id);
        o_sts.pend_valid = r_pend_valid;
        o_sts.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

// ----- rtl/core/ptt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer for add, remove and tick walks over the task list.
// ----------------------------------------------------------------------------
module ptt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ptt_pkg::t_ctl_sts i_sts,
    output ptt_pkg::t_ctl_cmd      o_cmd
);

    import ptt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_SWR  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;
    logic       advance;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign advance    = !i_sts.due || !i_sts.pend_valid || i_sts.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    unique case (i_sts.new_req) inside
                        REQ_TICK, REQ_REMOVE: begin
                            n_state = i_sts.cnt_zero ? S_FIN : S_RD;
                        end
                        REQ_ADD: begin
                            n_state = S_ADD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EV;
            end
            S_EV: begin
                if (i_sts.req == REQ_TICK) begin
                    if (advance) begin
                        if (i_sts.due) begin
                            o_cmd.wr_tick   = 1'b1;
                            o_cmd.take_pend = 1'b1;
                            o_cmd.emit_pend = i_sts.pend_valid;
                        end
                        if (i_sts.idx_end) begin
                            n_state = S_FIN;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = S_RD;
                        end
                    end
                end else if (i_sts.match) begin
                    o_cmd.set_ok = 1'b1;
                    if (i_sts.idx_end) begin
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = S_FIN;
                    end else begin
                        n_state = S_SRD;
                    end
                end else if (i_sts.idx_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_SRD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state       = S_SWR;
            end
            S_SWR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                if (i_sts.idx_end2) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_ADD: begin
                if (!i_sts.full) begin
                    o_cmd.wr_add  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.set_ok  = 1'b1;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/periodic_task_timer_bank_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_timer_bank_unit
// Ordered list of periodic task timers with add, remove and tick requests.
// ----------------------------------------------------------------------------
// One item is handled at a time. The task list sits in a single RAM with one
// read port and registered read data, so each entry visited takes an address
// step and then an evaluate step. A tick walks every entry and can also wait
// while the output side stalls; an add writes the new entry without a walk;
// a remove searches, then does a read/write shift of the tail.
// Each tick reports every fired task in list order, the final one flagged
// as last; a tick with nothing due gives a single idle result.
module periodic_task_timer_bank_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ptt_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ptt_pkg::t_out_item      o_out_item
);

    import ptt_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ptt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick, add and remove requests into the periodic task timer bank with
// random gaps and back-pressure, and checks each result item in order against
// a cycle-free copy of the ordered task list.
// ----------------------------------------------------------------------------
module testbench;
    import ptt_pkg::*;

    localparam int         IDLE_LIMIT   = 4000;
    localparam int         RANDOM_ITEMS = 150;
    localparam int         DRAIN_CYCLES = 80;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         HOLD_AFTER   = 60;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    class timer_bank_tracker;
        logic [15:0] ent_id[MAX_TASKS];
        logic [31:0] ent_interval[MAX_TASKS];
        logic [31:0] ent_last_ms[MAX_TASKS];
        int          n_entries;
        t_out_item   pending_results[$];
        int          errors;
        int          n_ticks;
        int          n_fired;
        int          n_adds;
        int          n_full;
        int          n_removes;
        int          n_absent;
        int          n_ignored;
        int          n_checked;

        function new();
            n_entries = 0;
            errors    = 0;
            n_ticks   = 0;
            n_fired   = 0;
            n_adds    = 0;
            n_full    = 0;
            n_removes = 0;
            n_absent  = 0;
            n_ignored = 0;
            n_checked = 0;
        endfunction

        function void push_result(logic [1:0] kind, logic ok, logic [15:0] id, logic lst);
            t_out_item r;
            r.result_kind = kind;
            r.ok          = ok;
            r.fired_id    = id;
            r.last        = lst;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void note_request(t_in_item it);
            int          i;
            int          hit;
            int          last_due;
            logic [31:0] elapsed;
            case (it.req_type)
                REQ_TICK: begin
                    n_ticks++;
                    last_due = -1;
                    for (i = 0; i < n_entries; i++) begin
                        elapsed = it.now_ms - ent_last_ms[i];
                        if (elapsed >= ent_interval[i]) last_due = i;
                    end
                    if (last_due < 0) begin
                        push_result(KIND_IDLE, 1'b0, 16'h0000, 1'b1);
                    end else begin
                        for (i = 0; i < n_entries; i++) begin
                            elapsed = it.now_ms - ent_last_ms[i];
                            if (elapsed >= ent_interval[i]) begin
                                ent_last_ms[i] = it.now_ms;
                                push_result(KIND_FIRED, 1'b1, ent_id[i], i == last_due);
                                n_fired++;
                            end
                        end
                    end
                end
                REQ_ADD: begin
                    n_adds++;
                    if (n_entries < MAX_TASKS) begin
                        ent_id[n_entries]       = it.task_id;
                        ent_interval[n_entries] = it.interval_ms;
                        ent_last_ms[n_entries]  = it.now_ms;
                        n_entries++;
                        push_result(KIND_ADD, 1'b1, it.task_id, 1'b1);
                    end else begin
                        n_full++;
                        push_result(KIND_ADD, 1'b0, it.task_id, 1'b1);
                    end
                end
                REQ_REMOVE: begin
                    n_removes++;
                    hit = -1;
                    for (i = 0; i < n_entries && hit < 0; i++)
                        if (ent_id[i] == it.task_id) hit = i;
                    if (hit >= 0) begin
                        for (i = hit; i + 1 < n_entries; i++) begin
                            ent_id[i]       = ent_id[i + 1];
                            ent_interval[i] = ent_interval[i + 1];
                            ent_last_ms[i]  = ent_last_ms[i + 1];
                        end
                        n_entries--;
                    end else begin
                        n_absent++;
                    end
                    push_result(KIND_REMOVE, hit >= 0, it.task_id, 1'b1);
                end
                default: n_ignored++;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("unexpected result item: result_kind %0d fired_id %0h",
                       got.result_kind, got.fired_id);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (got.result_kind !== want.result_kind) begin
                $error("result_kind expected %0d actual %0d", want.result_kind, got.result_kind);
                errors++;
            end
            if (got.ok !== want.ok) begin
                $error("ok expected %0d actual %0d", want.ok, got.ok);
                errors++;
            end
            if (got.fired_id !== want.fired_id) begin
                $error("fired_id expected %0h actual %0h", want.fired_id, got.fired_id);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in_item          in_item;
    logic              out_valid;
    logic              out_ready;
    t_out_item         out_item;
    int                quiet_cycles;
    timer_bank_tracker book;

    periodic_task_timer_bank_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial quiet_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) book.check_result(out_item);
            if (in_valid && in_ready) book.note_request(in_item);
            if ((out_valid && out_ready) || (in_valid && in_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $error("no item moved for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic offer_request(input logic [1:0] req, input logic [31:0] now_ms,
                                 input logic [15:0] id, input logic [31:0] interval,
                                 input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.req_type    = req;
        in_item.now_ms      = now_ms;
        in_item.task_id     = id;
        in_item.interval_ms = interval;
        in_valid            = 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (book.pending_results.size() != 0) @(negedge clk);
    endtask

    // result sink: random stalls, one long hold-off, stretches of steady ready
    initial begin : result_sink
        int gap;
        bit held;
        out_ready = 1'b0;
        held      = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && book.n_checked >= HOLD_AFTER) begin
                held      = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if ((book.n_checked / 25) % 4 != 3) begin
                gap = $urandom_range(0, 5);
                if (gap > 0) begin
                    out_ready = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : stimulus
        int          k;
        int          sent;
        int          r;
        int          add_cut;
        logic [1:0]  req;
        logic [15:0] id;
        logic [31:0] interval;
        logic [31:0] clock_ms;

        book     = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // empty list, absent id, unused request type
        offer_request(REQ_TICK, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0);
        offer_request(REQ_REMOVE, 32'h0000_0000, 16'h1234, 32'h0000_0000, 1'b0);
        offer_request(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        // fill the list: zero and max interval, extreme ids, a duplicate id
        offer_request(REQ_ADD, 32'hFFFF_FFF0, 16'h0000, 32'h0000_0000, 1'b0);
        offer_request(REQ_ADD, 32'hFFFF_FFF0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        offer_request(REQ_ADD, 32'hFFFF_FFF0, 16'h0005, 32'd20, 1'b0);
        offer_request(REQ_ADD, 32'hFFFF_FFF0, 16'h0005, 32'd100, 1'b0);
        for (k = 0; k < MAX_TASKS - 4; k++)
            offer_request(REQ_ADD, 32'hFFFF_FFF0, 16'(16'h0100 + k), k * 3, 1'b0);
        offer_request(REQ_ADD, 32'hFFFF_FFF2, 16'hAAAA, 32'd7, 1'b0);
        // time wraps; elapsed exactly equal to the interval on one entry
        offer_request(REQ_TICK, 32'h0000_0004, 16'h5555, 32'h5555_5555, 1'b0);
        offer_request(REQ_REMOVE, 32'h0000_0004, 16'h0005, 32'h0000_0000, 1'b0);
        offer_request(REQ_TICK, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        offer_request(REQ_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000, 1'b0);
        offer_request(REQ_REMOVE, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 1'b0);
        offer_request(REQ_TICK, 32'h0000_0010, 16'h0000, 32'h0000_0000, 1'b0);

        clock_ms = $urandom;
        sent     = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == RANDOM_ITEMS / 2) wait_for_drain();
            clock_ms += $urandom_range(0, 40);
            if ($urandom_range(0, 49) == 0) clock_ms += $urandom;
            add_cut = (sent < 60) ? 85 : (sent < 110) ? 55 : 70;
            r = $urandom_range(0, 99);
            if (r < 4) req = REQ_UNUSED;
            else if (r < 40) req = REQ_TICK;
            else if (r < add_cut) req = REQ_ADD;
            else req = REQ_REMOVE;
            id = 16'($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0) id = 16'($urandom);
            if (req == REQ_REMOVE && book.n_entries > 0 && $urandom_range(0, 3) != 0)
                id = book.ent_id[$urandom_range(0, book.n_entries - 1)];
            interval = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 150);
            offer_request(req, clock_ms, id, interval, (sent / 30) % 3 == 2);
            if (req != REQ_UNUSED) sent++;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("ran %0d ticks with %0d firings, %0d adds (%0d refused as full),",
                 book.n_ticks, book.n_fired, book.n_adds, book.n_full);
        $display("%0d removes (%0d of absent ids), %0d unused requests, %0d results checked",
                 book.n_removes, book.n_absent, book.n_ignored, book.n_checked);
        if (book.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
